[rtl/core/skr_pkg.sv]
`timescale 1ns / 1ps

package skr_pkg;

   localparam int COORD_W = 15;
   localparam int POS_W = 14;
   localparam int MAX_SEG = 64;
   localparam int IDX_W = $clog2(MAX_SEG);
   // holds the segment count and the pre-merge list length (up to MAX_SEG + 2)
   localparam int CNT_W = $clog2(MAX_SEG + 3);
   localparam int CSR_IDX_W = 4;

   localparam logic [COORD_W-1:0] COORD_LIMIT = COORD_W'(1 << (COORD_W - 1));
   localparam logic [COORD_W-1:0] ATLAS_RESET = COORD_W'(256);

   localparam logic [CSR_IDX_W-1:0] CSR_ATLAS_WIDTH = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ATLAS_HEIGHT = CSR_IDX_W'(1);

   localparam logic [1:0] STAT_OK = 2'd0;
   localparam logic [1:0] STAT_NOFIT = 2'd1;
   localparam logic [1:0] STAT_FULL = 2'd2;

   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE = 4'd0;
   localparam logic [OP_W-1:0] OP_INIT = 4'd1;
   localparam logic [OP_W-1:0] OP_RESTART = 4'd2;
   localparam logic [OP_W-1:0] OP_NOFIT = 4'd3;
   localparam logic [OP_W-1:0] OP_SCAN_START = 4'd4;
   localparam logic [OP_W-1:0] OP_SCAN_STEP = 4'd5;
   localparam logic [OP_W-1:0] OP_BUILD_START = 4'd6;
   localparam logic [OP_W-1:0] OP_PREFIX = 4'd7;
   localparam logic [OP_W-1:0] OP_NEWTOP = 4'd8;
   localparam logic [OP_W-1:0] OP_TRIM = 4'd9;
   localparam logic [OP_W-1:0] OP_SUFFIX = 4'd10;
   localparam logic [OP_W-1:0] OP_FLUSH = 4'd11;
   localparam logic [OP_W-1:0] OP_FINISH = 4'd12;

   typedef struct packed {
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] span;
   } seg_type;

   localparam int SEG_W = $bits(seg_type);

   typedef struct packed {
      logic [OP_W-1:0] op;
   } cmd_type;

   typedef struct packed {
      logic dims_zero;
      logic scan_done;
      logic found;
      logic best_zero;
      logic prefix_last;
      logic trim_exit;
      logic trim_cut;
      logic suffix_end;
   } sts_type;

   function automatic logic [COORD_W-1:0] clamp_dim(input logic [COORD_W-1:0] v);
      return (v > COORD_LIMIT) ? COORD_LIMIT : v;
   endfunction

endpackage

[rtl/core/skr_ram.sv]
`timescale 1ns / 1ps

module skr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/skr_ctrl.sv]
`timescale 1ns / 1ps

module skr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             req_action,
   input  skr_pkg::sts_type sts,
   output skr_pkg::cmd_type cmd,
   output logic             busy
);

   localparam logic [3:0] ST_INIT = 4'd0;
   localparam logic [3:0] ST_IDLE = 4'd1;
   localparam logic [3:0] ST_SCAN = 4'd2;
   localparam logic [3:0] ST_PICK = 4'd3;
   localparam logic [3:0] ST_PREFIX = 4'd4;
   localparam logic [3:0] ST_NEWTOP = 4'd5;
   localparam logic [3:0] ST_TRIM = 4'd6;
   localparam logic [3:0] ST_SUFFIX = 4'd7;
   localparam logic [3:0] ST_FLUSH = 4'd8;
   localparam logic [3:0] ST_FINISH = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op = skr_pkg::OP_NONE;
      case (state_ff)
         ST_INIT: begin
            cmd.op = skr_pkg::OP_INIT;
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               if (!req_action) begin
                  cmd.op = skr_pkg::OP_RESTART;
               end else if (sts.dims_zero) begin
                  cmd.op = skr_pkg::OP_NOFIT;
               end else begin
                  cmd.op = skr_pkg::OP_SCAN_START;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.op = skr_pkg::OP_SCAN_STEP;
            if (sts.scan_done) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            if (sts.found) begin
               cmd.op = skr_pkg::OP_BUILD_START;
               state_in = sts.best_zero ? ST_NEWTOP : ST_PREFIX;
            end else begin
               cmd.op = skr_pkg::OP_NOFIT;
               state_in = ST_IDLE;
            end
         end
         ST_PREFIX: begin
            cmd.op = skr_pkg::OP_PREFIX;
            if (sts.prefix_last) begin
               state_in = ST_NEWTOP;
            end
         end
         ST_NEWTOP: begin
            cmd.op = skr_pkg::OP_NEWTOP;
            state_in = ST_TRIM;
         end
         ST_TRIM: begin
            cmd.op = skr_pkg::OP_TRIM;
            if (sts.trim_exit || sts.trim_cut) begin
               state_in = ST_SUFFIX;
            end
         end
         ST_SUFFIX: begin
            cmd.op = skr_pkg::OP_SUFFIX;
            if (sts.suffix_end) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            cmd.op = skr_pkg::OP_FLUSH;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.op = skr_pkg::OP_FINISH;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

[rtl/core/skr_datapath.sv]
`timescale 1ns / 1ps

module skr_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  skr_pkg::cmd_type                  cmd,
   output skr_pkg::sts_type                  sts,
   input  logic [skr_pkg::COORD_W-1:0]       req_rect_width,
   input  logic [skr_pkg::COORD_W-1:0]       req_rect_height,
   input  logic                              csr_wr_en,
   input  logic [skr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [skr_pkg::COORD_W-1:0]       csr_wdata,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic [skr_pkg::POS_W-1:0]         rsp_pos_x,
   output logic [skr_pkg::POS_W-1:0]         rsp_pos_y
);

   localparam logic [skr_pkg::CNT_W-1:0] CNT_ONE = skr_pkg::CNT_W'(1);
   localparam logic [skr_pkg::CNT_W-1:0] CNT_MAX = skr_pkg::CNT_W'(skr_pkg::MAX_SEG);

   // control state
   logic [skr_pkg::COORD_W-1:0] aw_ff, aw_in, ah_ff, ah_in;
   logic                        bank_ff, bank_in;
   logic [skr_pkg::CNT_W-1:0]   count_ff, count_in;
   logic                        found_ff, found_in;
   logic                        pend_v_ff, pend_v_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // payload
   logic [skr_pkg::COORD_W-1:0] w_ff, w_in, h_ff, h_in;
   logic [skr_pkg::CNT_W-1:0]   i_ff, i_in, idx_ff, idx_in;
   logic [skr_pkg::COORD_W-1:0] max_y_ff, max_y_in, rem_ff, rem_in;
   logic [skr_pkg::COORD_W-1:0] span_i_ff, span_i_in, left_i_ff, left_i_in;
   logic [skr_pkg::CNT_W-1:0]   best_ff, best_in;
   logic [skr_pkg::COORD_W-1:0] best_y_ff, best_y_in, best_span_ff, best_span_in;
   logic [skr_pkg::COORD_W-1:0] best_x_ff, best_x_in, right_ff, right_in;
   logic [skr_pkg::CNT_W-1:0]   t_ff, t_in, m_ff, m_in;
   skr_pkg::seg_type            pend_ff, pend_in;
   logic [1:0]                  rsp_status_ff, rsp_status_in;
   logic [skr_pkg::POS_W-1:0]   rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;

   // store banks: one holds the live list, the other takes the rebuilt one
   skr_pkg::seg_type            rd0, rd1, d;
   logic [skr_pkg::IDX_W-1:0]   rd_addr;
   logic                        wr_act, wr_bld;
   skr_pkg::seg_type            act_seg;
   logic                        wr0_en, wr1_en;
   logic [skr_pkg::IDX_W-1:0]   wr0_addr, wr1_addr;
   skr_pkg::seg_type            wr0_data, wr1_data;

   logic [skr_pkg::COORD_W-1:0] aw_c, ah_c;

   // scan terms
   logic                        first;
   logic [skr_pkg::COORD_W-1:0] span_i, left_i, top_max, rem_cur, take, rem_nxt;
   logic                        fit_x_fail, fit_y_fail, last_j, end_i, better;

   // build terms
   logic [skr_pkg::COORD_W:0]   d_right;
   logic                        trim_exit, trim_cut, suffix_end, prefix_last;
   logic                        emit_v, merge, m_room;
   skr_pkg::seg_type            emit_seg;

   assign d = bank_ff ? rd1 : rd0;
   assign aw_c = skr_pkg::clamp_dim(aw_ff);
   assign ah_c = skr_pkg::clamp_dim(ah_ff);

   assign first = (idx_ff == i_ff);
   assign span_i = first ? d.span : span_i_ff;
   assign left_i = first ? d.left : left_i_ff;
   assign fit_x_fail = first && (({1'b0, d.left} + {1'b0, w_ff}) > {1'b0, aw_c});
   assign top_max = first ? d.top : ((d.top > max_y_ff) ? d.top : max_y_ff);
   assign fit_y_fail = ({1'b0, top_max} + {1'b0, h_ff}) > {1'b0, ah_c};
   assign rem_cur = first ? w_ff : rem_ff;
   assign take = (d.span < rem_cur) ? d.span : rem_cur;
   assign rem_nxt = rem_cur - take;
   assign last_j = ((idx_ff + CNT_ONE) == count_ff);
   assign end_i = fit_x_fail || fit_y_fail || (rem_nxt == '0) || last_j;
   assign better = !found_ff || (top_max < best_y_ff) ||
                   ((top_max == best_y_ff) && (span_i < best_span_ff));

   assign d_right = {1'b0, d.left} + {1'b0, d.span};
   assign trim_exit = (idx_ff >= count_ff) || (d.left >= right_ff);
   assign trim_cut = !trim_exit && (d_right > {1'b0, right_ff});
   assign suffix_end = (idx_ff >= count_ff) || (t_ff > CNT_MAX);
   assign prefix_last = ((idx_ff + CNT_ONE) == best_ff);
   assign m_room = (m_ff < CNT_MAX);

   always_comb begin
      emit_v = 1'b0;
      emit_seg = d;
      case (cmd.op)
         skr_pkg::OP_PREFIX: begin
            emit_v = 1'b1;
         end
         skr_pkg::OP_NEWTOP: begin
            emit_v = 1'b1;
            emit_seg.left = best_x_ff;
            emit_seg.top = best_y_ff + h_ff;
            emit_seg.span = w_ff;
         end
         skr_pkg::OP_TRIM: begin
            emit_v = trim_cut;
            emit_seg.left = right_ff;
            emit_seg.span = d_right[skr_pkg::COORD_W-1:0] - right_ff;
         end
         skr_pkg::OP_SUFFIX: begin
            emit_v = !suffix_end;
         end
         default: begin
            emit_v = 1'b0;
         end
      endcase
   end

   assign merge = pend_v_ff && (pend_ff.top == emit_seg.top);

   assign wr_act = (cmd.op == skr_pkg::OP_INIT) || (cmd.op == skr_pkg::OP_RESTART);
   assign wr_bld = ((emit_v && !merge && pend_v_ff) || (cmd.op == skr_pkg::OP_FLUSH)) && m_room;
   assign act_seg = '{left: '0, top: '0, span: aw_c};

   assign wr0_en = bank_ff ? wr_bld : wr_act;
   assign wr1_en = bank_ff ? wr_act : wr_bld;
   assign wr0_addr = bank_ff ? m_ff[skr_pkg::IDX_W-1:0] : '0;
   assign wr1_addr = bank_ff ? '0 : m_ff[skr_pkg::IDX_W-1:0];
   assign wr0_data = bank_ff ? pend_ff : act_seg;
   assign wr1_data = bank_ff ? act_seg : pend_ff;
   assign rd_addr = idx_in[skr_pkg::IDX_W-1:0];

   skr_ram #(.WIDTH(skr_pkg::SEG_W), .DEPTH(skr_pkg::MAX_SEG)) u_bank0 (
      .clock   (clock),
      .wr_en   (wr0_en),
      .wr_addr (wr0_addr),
      .wr_data (wr0_data),
      .rd_addr (rd_addr),
      .rd_data (rd0)
   );

   skr_ram #(.WIDTH(skr_pkg::SEG_W), .DEPTH(skr_pkg::MAX_SEG)) u_bank1 (
      .clock   (clock),
      .wr_en   (wr1_en),
      .wr_addr (wr1_addr),
      .wr_data (wr1_data),
      .rd_addr (rd_addr),
      .rd_data (rd1)
   );

   always_comb begin
      aw_in = aw_ff;
      ah_in = ah_ff;
      bank_in = bank_ff;
      count_in = count_ff;
      found_in = found_ff;
      pend_v_in = pend_v_ff;
      rsp_valid_in = 1'b0;
      w_in = w_ff;
      h_in = h_ff;
      i_in = i_ff;
      idx_in = idx_ff;
      max_y_in = max_y_ff;
      rem_in = rem_ff;
      span_i_in = span_i_ff;
      left_i_in = left_i_ff;
      best_in = best_ff;
      best_y_in = best_y_ff;
      best_span_in = best_span_ff;
      best_x_in = best_x_ff;
      right_in = right_ff;
      t_in = t_ff;
      m_in = m_ff;
      pend_in = pend_ff;
      rsp_status_in = rsp_status_ff;
      rsp_x_in = rsp_x_ff;
      rsp_y_in = rsp_y_ff;

      if (csr_wr_en && (csr_index == skr_pkg::CSR_ATLAS_WIDTH)) begin
         aw_in = csr_wdata;
      end
      if (csr_wr_en && (csr_index == skr_pkg::CSR_ATLAS_HEIGHT)) begin
         ah_in = csr_wdata;
      end

      // merge on the fly into the pending entry
      if (emit_v) begin
         t_in = t_ff + CNT_ONE;
         pend_v_in = 1'b1;
         if (merge) begin
            pend_in.span = pend_ff.span + emit_seg.span;
         end else begin
            pend_in = emit_seg;
            if (pend_v_ff) begin
               m_in = m_ff + CNT_ONE;
            end
         end
      end

      case (cmd.op)
         skr_pkg::OP_RESTART: begin
            count_in = CNT_ONE;
            rsp_valid_in = 1'b1;
            rsp_status_in = skr_pkg::STAT_OK;
            rsp_x_in = '0;
            rsp_y_in = '0;
         end
         skr_pkg::OP_NOFIT: begin
            rsp_valid_in = 1'b1;
            rsp_status_in = skr_pkg::STAT_NOFIT;
            rsp_x_in = '0;
            rsp_y_in = '0;
         end
         skr_pkg::OP_SCAN_START: begin
            w_in = req_rect_width;
            h_in = req_rect_height;
            i_in = '0;
            idx_in = '0;
            found_in = 1'b0;
         end
         skr_pkg::OP_SCAN_STEP: begin
            if (end_i) begin
               if (!fit_x_fail && !fit_y_fail && (rem_nxt == '0) && better) begin
                  found_in = 1'b1;
                  best_in = i_ff;
                  best_y_in = top_max;
                  best_span_in = span_i;
                  best_x_in = left_i;
               end
               i_in = i_ff + CNT_ONE;
               idx_in = i_ff + CNT_ONE;
            end else begin
               idx_in = idx_ff + CNT_ONE;
               max_y_in = top_max;
               rem_in = rem_nxt;
               span_i_in = span_i;
               left_i_in = left_i;
            end
         end
         skr_pkg::OP_BUILD_START: begin
            idx_in = '0;
            t_in = '0;
            m_in = '0;
            pend_v_in = 1'b0;
            right_in = best_x_ff + w_ff;
         end
         skr_pkg::OP_PREFIX: begin
            idx_in = idx_ff + CNT_ONE;
         end
         skr_pkg::OP_TRIM: begin
            if (!trim_exit) begin
               idx_in = idx_ff + CNT_ONE;
            end
         end
         skr_pkg::OP_SUFFIX: begin
            if (!suffix_end) begin
               idx_in = idx_ff + CNT_ONE;
            end
         end
         skr_pkg::OP_FLUSH: begin
            m_in = m_ff + CNT_ONE;
         end
         skr_pkg::OP_FINISH: begin
            rsp_valid_in = 1'b1;
            if (m_ff > CNT_MAX) begin
               rsp_status_in = skr_pkg::STAT_FULL;
               rsp_x_in = '0;
               rsp_y_in = '0;
            end else begin
               bank_in = !bank_ff;
               count_in = m_ff;
               rsp_status_in = skr_pkg::STAT_OK;
               rsp_x_in = best_x_ff[skr_pkg::POS_W-1:0];
               rsp_y_in = best_y_ff[skr_pkg::POS_W-1:0];
            end
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         aw_ff <= skr_pkg::ATLAS_RESET;
         ah_ff <= skr_pkg::ATLAS_RESET;
         bank_ff <= 1'b0;
         count_ff <= CNT_ONE;
         found_ff <= 1'b0;
         pend_v_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         aw_ff <= aw_in;
         ah_ff <= ah_in;
         bank_ff <= bank_in;
         count_ff <= count_in;
         found_ff <= found_in;
         pend_v_ff <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      h_ff <= h_in;
      i_ff <= i_in;
      idx_ff <= idx_in;
      max_y_ff <= max_y_in;
      rem_ff <= rem_in;
      span_i_ff <= span_i_in;
      left_i_ff <= left_i_in;
      best_ff <= best_in;
      best_y_ff <= best_y_in;
      best_span_ff <= best_span_in;
      best_x_ff <= best_x_in;
      right_ff <= right_in;
      t_ff <= t_in;
      m_ff <= m_in;
      pend_ff <= pend_in;
      rsp_status_ff <= rsp_status_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
   end

   assign sts.dims_zero = (req_rect_width == '0) || (req_rect_height == '0);
   assign sts.scan_done = end_i && ((i_ff + CNT_ONE) == count_ff);
   assign sts.found = found_ff;
   assign sts.best_zero = (best_ff == '0);
   assign sts.prefix_last = prefix_last;
   assign sts.trim_exit = trim_exit;
   assign sts.trim_cut = trim_cut;
   assign sts.suffix_end = suffix_end;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_pos_x = rsp_x_ff;
   assign rsp_pos_y = rsp_y_ff;

endmodule

[rtl/core/skyline_rect_packer_core.sv]
`timescale 1ns / 1ps

// skyline bottom-left rectangle packer. a beat is taken when start is high and
// busy is low; exactly one result beat follows on rsp_valid for one cycle and
// the receiver cannot stall it. a restart, or a place with zero width or height,
// answers in the next cycle. a place runs a scan and then a rebuild: the scan
// reads one segment per cycle from a single registered ram port, candidate i
// reading segments i.. until its width is covered; the rebuild then streams
// the list once into the spare bank. after reset busy stays high for one
// cycle while the first segment is written.
module skyline_rect_packer_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_action,
   input  logic [skr_pkg::COORD_W-1:0]   req_rect_width,
   input  logic [skr_pkg::COORD_W-1:0]   req_rect_height,
   input  logic                          csr_wr_en,
   input  logic [skr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [skr_pkg::COORD_W-1:0]   csr_wdata,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic [skr_pkg::POS_W-1:0]     rsp_pos_x,
   output logic [skr_pkg::POS_W-1:0]     rsp_pos_y
);

   // command and status between sequencer and datapath
   skr_pkg::cmd_type cmd;
   skr_pkg::sts_type sts;

   // sequencer: scan, pick, rebuild phases
   skr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .sts        (sts),
      .cmd        (cmd),
      .busy       (busy)
   );

   // datapath: two segment banks, scan and merge logic, csr and result regs
   skr_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y)
   );

endmodule

[rtl/core/skr_checker.sv]
`timescale 1ns / 1ps

module skr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          req_action,
   input logic [skr_pkg::COORD_W-1:0]   req_rect_width,
   input logic [skr_pkg::COORD_W-1:0]   req_rect_height,
   input logic                          rsp_valid,
   input logic [1:0]                    rsp_status,
   input logic [skr_pkg::POS_W-1:0]     rsp_pos_x,
   input logic [skr_pkg::POS_W-1:0]     rsp_pos_y
);

   // restart answers in the next cycle
   a_restart: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_action |=> rsp_valid && (rsp_status == skr_pkg::STAT_OK))
      else $error("restart not answered next cycle");

   // zero-sized place answers no-fit next cycle
   a_zero: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_action &&
      ((req_rect_width == '0) || (req_rect_height == '0))
      |=> rsp_valid && (rsp_status == skr_pkg::STAT_NOFIT))
      else $error("zero-sized place not rejected");

   // failed results carry zero position
   a_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != skr_pkg::STAT_OK) |-> (rsp_pos_x == '0) && (rsp_pos_y == '0))
      else $error("position set on failed result");

   // a place that starts a scan leaves the port busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_action && (req_rect_width != '0) && (req_rect_height != '0)
      |=> busy && !rsp_valid)
      else $error("place scan did not hold busy");

endmodule

bind skyline_rect_packer_core skr_checker u_skr_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_action      (req_action),
   .req_rect_width  (req_rect_width),
   .req_rect_height (req_rect_height),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_pos_x       (rsp_pos_x),
   .rsp_pos_y       (rsp_pos_y)
);

[sim/tb_top.sv]
`timescale 1ns / 1ps

// testbench for the skyline rectangle packer
// a queue of pending beats (place/restart items and register writes) feeds a
// clocked driver; the driver updates a local skyline model at every accepted
// beat and queues the expected answer, which the monitor checks on rsp_valid
module tb_top;

   localparam logic ACT_RESTART = 1'b0;
   localparam logic ACT_PLACE = 1'b1;
   localparam int unsigned LIMIT = 16384;

   typedef enum logic {BEAT_ITEM, BEAT_CSR} beat_kind_type;

   typedef struct {
      beat_kind_type kind;
      logic action;
      logic [skr_pkg::COORD_W-1:0] w;
      logic [skr_pkg::COORD_W-1:0] h;
      logic [skr_pkg::CSR_IDX_W-1:0] idx;
      logic [skr_pkg::COORD_W-1:0] data;
   } beat_type;

   typedef struct {
      logic [1:0] status;
      logic [skr_pkg::POS_W-1:0] x;
      logic [skr_pkg::POS_W-1:0] y;
   } placement_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_action = 1'b0;
   logic [skr_pkg::COORD_W-1:0] req_rect_width = '0;
   logic [skr_pkg::COORD_W-1:0] req_rect_height = '0;
   logic csr_wr_en = 1'b0;
   logic [skr_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [skr_pkg::COORD_W-1:0] csr_wdata = '0;
   logic rsp_valid;
   logic [1:0] rsp_status;
   logic [skr_pkg::POS_W-1:0] rsp_pos_x;
   logic [skr_pkg::POS_W-1:0] rsp_pos_y;

   skyline_rect_packer_core u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_rect_width(req_rect_width),
      .req_rect_height(req_rect_height), .csr_wr_en(csr_wr_en),
      .csr_index(csr_index), .csr_wdata(csr_wdata), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------
   // skyline model: configuration, segment list, expected placements
   // ---------------------------------------------------------------
   int unsigned atlas_w_reg, atlas_h_reg;
   int unsigned sky_left[skr_pkg::MAX_SEG];
   int unsigned sky_top[skr_pkg::MAX_SEG];
   int unsigned sky_span[skr_pkg::MAX_SEG];
   int unsigned sky_count;
   int unsigned nl[skr_pkg::MAX_SEG+2];
   int unsigned nt[skr_pkg::MAX_SEG+2];
   int unsigned ns[skr_pkg::MAX_SEG+2];

   placement_type placements_due[$];
   beat_type pending_beats[$];

   int errors = 0;
   int n_items = 0;
   int n_placed = 0, n_nofit = 0, n_full = 0;

   function automatic int unsigned clip(int unsigned v);
      return (v > LIMIT) ? LIMIT : v;
   endfunction

   function automatic void skyline_clear();
      for (int k = 0; k < skr_pkg::MAX_SEG; k++) begin
         sky_left[k] = 0;
         sky_top[k] = 0;
         sky_span[k] = 0;
      end
      sky_span[0] = clip(atlas_w_reg);
      sky_count = 1;
   endfunction

   function automatic void apply_csr(logic [skr_pkg::CSR_IDX_W-1:0] idx,
                                     logic [skr_pkg::COORD_W-1:0] d);
      if (idx == skr_pkg::CSR_ATLAS_WIDTH) atlas_w_reg = d;
      else if (idx == skr_pkg::CSR_ATLAS_HEIGHT) atlas_h_reg = d;
   endfunction

   // bottom-left choice over all start segments, then rebuild and merge
   function automatic placement_type pack_rect(logic act, int unsigned w, int unsigned h);
      placement_type r;
      int unsigned aw, ah, n, best, best_y, best_span, t, m, k, x0, right;
      int unsigned max_y, rem, take, node_right;
      bit found, fits;
      r = '{skr_pkg::STAT_OK, '0, '0};
      aw = clip(atlas_w_reg);
      ah = clip(atlas_h_reg);
      n = sky_count;
      found = 0;
      best = 0;
      best_y = 0;
      best_span = 0;
      if (act == ACT_RESTART) begin
         skyline_clear();
         return r;
      end
      if (w != 0 && h != 0) begin
         for (int i = 0; i < n; i++) begin
            if (sky_left[i] + w > aw) continue;
            max_y = sky_top[i];
            rem = w;
            fits = 1;
            for (int j = i; rem > 0 && j < n; j++) begin
               if (sky_top[j] > max_y) max_y = sky_top[j];
               if (max_y + h > ah) begin
                  fits = 0;
                  break;
               end
               take = (sky_span[j] < rem) ? sky_span[j] : rem;
               rem -= take;
            end
            if (!fits || rem > 0) continue;
            if (!found || max_y < best_y || (max_y == best_y && sky_span[i] < best_span)) begin
               found = 1;
               best = i;
               best_y = max_y;
               best_span = sky_span[i];
            end
         end
      end
      if (!found) begin
         r.status = skr_pkg::STAT_NOFIT;
         return r;
      end
      x0 = sky_left[best];
      right = x0 + w;
      t = 0;
      for (k = 0; k < best; k++) begin
         nl[t] = sky_left[k]; nt[t] = sky_top[k]; ns[t] = sky_span[k]; t++;
      end
      nl[t] = x0; nt[t] = best_y + h; ns[t] = w; t++;
      k = best;
      while (k < n && sky_left[k] < right) begin
         node_right = sky_left[k] + sky_span[k];
         k++;
         if (node_right > right) begin
            nl[t] = right; nt[t] = sky_top[k-1]; ns[t] = node_right - right; t++;
            break;
         end
      end
      for (; k < n && t <= skr_pkg::MAX_SEG; k++) begin
         nl[t] = sky_left[k]; nt[t] = sky_top[k]; ns[t] = sky_span[k]; t++;
      end
      m = 0;
      for (k = 0; k < t; k++) begin
         if (m > 0 && nt[m-1] == nt[k]) begin
            ns[m-1] += ns[k];
         end else begin
            nl[m] = nl[k]; nt[m] = nt[k]; ns[m] = ns[k]; m++;
         end
      end
      if (m > skr_pkg::MAX_SEG) begin
         r.status = skr_pkg::STAT_FULL;
         return r;
      end
      for (k = 0; k < skr_pkg::MAX_SEG; k++) begin
         sky_left[k] = (k < m) ? nl[k] : 0;
         sky_top[k] = (k < m) ? nt[k] : 0;
         sky_span[k] = (k < m) ? ns[k] : 0;
      end
      sky_count = m;
      r.x = x0[skr_pkg::POS_W-1:0];
      r.y = best_y[skr_pkg::POS_W-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------
   // driver: bursts of items with random gaps, register writes only
   // once every expected answer is back and the block is quiet
   // ---------------------------------------------------------------
   int burst_left = 0;
   int gap_left = 0;
   int quiet = 0;

   always @(posedge clock) begin
      bit take_beat, next_start, next_wr;
      beat_type b;
      placement_type p;
      take_beat = start && !busy;
      next_start = start && !take_beat;
      next_wr = 1'b0;
      if (reset) begin
         next_start = 1'b0;
      end else begin
         if (take_beat) begin
            p = pack_rect(req_action, req_rect_width, req_rect_height);
            placements_due = {placements_due, p};
         end
         quiet = (take_beat || rsp_valid) ? 0 : quiet + 1;
         if (!next_start) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_beats.size() > 0) begin
               b = pending_beats[0];
               if (b.kind == BEAT_CSR) begin
                  // idle window: nothing outstanding and no activity for a while
                  if (placements_due.size() == 0 && !busy && quiet >= 6) begin
                     void'(pending_beats.pop_front());
                     apply_csr(b.idx, b.data);
                     next_wr = 1'b1;
                     csr_index <= b.idx;
                     csr_wdata <= b.data;
                  end
               end else begin
                  void'(pending_beats.pop_front());
                  next_start = 1'b1;
                  req_action <= b.action;
                  req_rect_width <= b.w;
                  req_rect_height <= b.h;
                  if (burst_left > 0) begin
                     burst_left--;
                  end else begin
                     // stretches of back-to-back beats, then random gaps
                     burst_left = $urandom_range(0, 12);
                     gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                  end
               end
            end
         end
      end
      start <= next_start;
      csr_wr_en <= next_wr;
   end

   // ---------------------------------------------------------------
   // monitor: every answer beat against the oldest expectation
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      placement_type e;
      if (!reset && rsp_valid) begin
         if (placements_due.size() == 0) begin
            $display("%0t: unexpected answer status=%0d x=%0d y=%0d", $time,
                     rsp_status, rsp_pos_x, rsp_pos_y);
            errors++;
         end else begin
            e = placements_due.pop_front();
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_status);
               errors++;
            end
            if (rsp_pos_x !== e.x) begin
               $display("%0t: pos_x expected %0d actual %0d", $time, e.x, rsp_pos_x);
               errors++;
            end
            if (rsp_pos_y !== e.y) begin
               $display("%0t: pos_y expected %0d actual %0d", $time, e.y, rsp_pos_y);
               errors++;
            end
            case (e.status)
               skr_pkg::STAT_OK: n_placed++;
               skr_pkg::STAT_NOFIT: n_nofit++;
               default: n_full++;
            endcase
         end
      end
   end

   function automatic void add_item(logic act, int unsigned w, int unsigned h);
      beat_type b;
      b.kind = BEAT_ITEM;
      b.action = act;
      b.w = w[skr_pkg::COORD_W-1:0];
      b.h = h[skr_pkg::COORD_W-1:0];
      b.idx = '0;
      b.data = '0;
      pending_beats = {pending_beats, b};
      n_items++;
   endfunction

   function automatic void add_csr(logic [skr_pkg::CSR_IDX_W-1:0] idx, int unsigned d);
      beat_type b;
      b.kind = BEAT_CSR;
      b.action = ACT_RESTART;
      b.w = '0;
      b.h = '0;
      b.idx = idx;
      b.data = d[skr_pkg::COORD_W-1:0];
      pending_beats = {pending_beats, b};
   endfunction

   function automatic int unsigned pick_dim();
      case ($urandom_range(0, 7))
         0: return 1;
         1: return LIMIT;
         2: return $urandom_range(LIMIT + 1, 32767);
         default: return $urandom_range(16, 300);
      endcase
   endfunction

   // ---------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------
   initial begin
      int unsigned aw, ah, len;
      atlas_w_reg = skr_pkg::ATLAS_RESET;
      atlas_h_reg = skr_pkg::ATLAS_RESET;
      skyline_clear();

      // directed: reset skyline, zero sizes, extremes, clamping
      add_item(ACT_PLACE, 10, 20);
      add_item(ACT_PLACE, 0, 5);
      add_item(ACT_PLACE, 5, 0);
      add_item(ACT_PLACE, 32767, 32767);
      add_item(ACT_RESTART, 32767, 32767);
      add_item(ACT_PLACE, 256, 256);
      add_item(ACT_PLACE, 1, 1);
      // zero-width atlas builds an empty skyline
      add_csr(skr_pkg::CSR_ATLAS_WIDTH, 0);
      add_item(ACT_RESTART, 0, 0);
      add_item(ACT_PLACE, 1, 1);
      // oversized registers act as the coordinate limit
      add_csr(skr_pkg::CSR_ATLAS_WIDTH, 32767);
      add_csr(skr_pkg::CSR_ATLAS_HEIGHT, 32767);
      add_csr(4'd5, 77);
      add_item(ACT_RESTART, 0, 0);
      add_item(ACT_PLACE, 16383, 5);
      add_item(ACT_PLACE, 1, 16384);
      add_item(ACT_PLACE, 16384, 16384);
      // zero-height atlas: nothing fits
      add_csr(skr_pkg::CSR_ATLAS_HEIGHT, 0);
      add_item(ACT_PLACE, 1, 1);
      // narrow skyline, then a wider atlas without restart
      add_csr(skr_pkg::CSR_ATLAS_HEIGHT, 256);
      add_csr(skr_pkg::CSR_ATLAS_WIDTH, 100);
      add_item(ACT_RESTART, 0, 0);
      add_csr(skr_pkg::CSR_ATLAS_WIDTH, 300);
      add_item(ACT_PLACE, 150, 3);
      add_item(ACT_PLACE, 60, 3);
      // comb of unit-wide columns until the segment store overflows
      add_csr(skr_pkg::CSR_ATLAS_WIDTH, 256);
      add_item(ACT_RESTART, 0, 0);
      for (int i = 0; i < 70; i++) add_item(ACT_PLACE, 1, (i % 2) + 1);

      // random phases with a fresh atlas each
      while (n_items < 1170) begin
         aw = pick_dim();
         ah = pick_dim();
         add_csr(skr_pkg::CSR_ATLAS_WIDTH, aw);
         add_csr(skr_pkg::CSR_ATLAS_HEIGHT, ah);
         add_item(ACT_RESTART, $urandom_range(0, 32767), $urandom_range(0, 32767));
         aw = clip(aw);
         ah = clip(ah);
         len = $urandom_range(15, 60);
         for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 19))
               0: add_item(ACT_RESTART, $urandom_range(0, 32767), $urandom_range(0, 32767));
               1, 2: add_item(ACT_PLACE, $urandom_range(0, 32767), $urandom_range(0, 32767));
               3: add_item(ACT_PLACE, 1, $urandom_range(1, 3));
               default: add_item(ACT_PLACE, $urandom_range(1, (aw > 12) ? aw / 4 : 3),
                                 $urandom_range(1, (ah > 12) ? ah / 5 : 3));
            endcase
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // sample between edges so the driver and monitor have settled
      do begin
         @(negedge clock);
      end while (pending_beats.size() != 0 || start || busy || placements_due.size() != 0);
      repeat (20) @(posedge clock);
      $display("run covered %0d item beats: %0d placed or restarted, %0d no-fit, %0d store full",
               n_items, n_placed, n_nofit, n_full);
      if (errors == 0 && placements_due.size() == 0) begin
         $display("** skyline_rect_packer_core: PASSED **");
      end else begin
         $display("** skyline_rect_packer_core: FAILED **");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d answers outstanding", placements_due.size());
      $display("** skyline_rect_packer_core: FAILED **");
      $finish;
   end

endmodule
